// File: design/lts_pkg.sv
// Package with shared types, codes and sizing constants for the stop-and-wait sender.
package lts_pkg;

  // Sizing constants.
  localparam int COUNT_WIDTH  = 16;
  localparam int HANDLE_WIDTH = 8;

  // Fixed field widths.
  localparam int REQ_W    = 2;
  localparam int SEQ_W    = 2;
  localparam int KIND_W   = 2;
  localparam int PCT_W    = 7;
  localparam int PORT_W   = 16;
  localparam int BUF_W    = 8;
  localparam int LEN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W   = COUNT_WIDTH + PCT_W;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SEND    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

  // Result codes.
  localparam logic [KIND_W-1:0] KIND_TRANSMIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVERED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOLERATED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED   = 2'd3;

  // Sequence numbers.
  localparam logic [SEQ_W-1:0] SEQ_ONE = 2'd1;
  localparam logic [SEQ_W-1:0] SEQ_TWO = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT  = 2'd2;

  // Configuration reset values.
  localparam logic [PCT_W-1:0]  THRESHOLD_RST = 7'd60;
  localparam logic [PCT_W-1:0]  PCT_SCALE     = 7'd100;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [BUF_W-1:0] HANDLE_MASK =
    (HANDLE_WIDTH >= BUF_W) ? {BUF_W{1'b1}} : BUF_W'((64'd1 << HANDLE_WIDTH) - 64'd1);

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [SEQ_W-1:0] ack_number;
    logic [BUF_W-1:0] buffer_id;
    logic [LEN_W-1:0] msg_len;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [SEQ_W-1:0]  seq_out;
    logic              prev_tolerated;
    logic [PORT_W-1:0] port_from;
    logic [PORT_W-1:0] port_to;
    logic [BUF_W-1:0]  payload_handle;
    logic [LEN_W-1:0]  payload_len;
  } res_t;

  typedef struct packed {
    logic [PCT_W-1:0]  loss_threshold_pct;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
  } cfg_t;

endpackage

// File: design/lts_ifs.sv
// Channel interfaces for requests, results and configuration writes.
interface lts_in_if;
  logic                        valid;
  logic                        ready;
  logic [lts_pkg::REQ_W-1:0]   req_type;
  logic [lts_pkg::SEQ_W-1:0]   ack_number;
  logic [lts_pkg::BUF_W-1:0]   buffer_id;
  logic [lts_pkg::LEN_W-1:0]   msg_len;

  modport source (output valid, req_type, ack_number, buffer_id, msg_len, input ready);
  modport sink   (input valid, req_type, ack_number, buffer_id, msg_len, output ready);
endinterface

interface lts_out_if;
  logic                        valid;
  logic                        ready;
  logic [lts_pkg::KIND_W-1:0]  result_kind;
  logic [lts_pkg::SEQ_W-1:0]   seq_out;
  logic                        prev_tolerated;
  logic [lts_pkg::PORT_W-1:0]  port_from;
  logic [lts_pkg::PORT_W-1:0]  port_to;
  logic [lts_pkg::BUF_W-1:0]   payload_handle;
  logic [lts_pkg::LEN_W-1:0]   payload_len;

  modport source (output valid, result_kind, seq_out, prev_tolerated, port_from, port_to,
                  payload_handle, payload_len, input ready);
  modport sink   (input valid, result_kind, seq_out, prev_tolerated, port_from, port_to,
                  payload_handle, payload_len, output ready);
endinterface

interface lts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lts_pkg::CFG_IDX_W-1:0]  index;
  logic [lts_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/lts_cfg_regs.sv
// Configuration register file: threshold and header ports.
module lts_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  lts_cfg_if.sink         cfg_if,
  output lts_pkg::cfg_t   cfg
);

  lts_pkg::cfg_t cfg_r;
  lts_pkg::cfg_t cfg_nxt;

  // Writes are always taken; an unknown index changes nothing.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        lts_pkg::CFG_THRESHOLD: cfg_nxt.loss_threshold_pct = cfg_if.data[lts_pkg::PCT_W-1:0];
        lts_pkg::CFG_SRC_PORT:  cfg_nxt.src_port = cfg_if.data[lts_pkg::PORT_W-1:0];
        lts_pkg::CFG_DST_PORT:  cfg_nxt.dst_port = cfg_if.data[lts_pkg::PORT_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loss_threshold_pct <= lts_pkg::THRESHOLD_RST;
      cfg_r.src_port           <= '0;
      cfg_r.dst_port           <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/lts_core.sv
// Protocol state and combinational event evaluation of the sender.
module lts_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  lts_pkg::req_t   req,
  input  lts_pkg::cfg_t   cfg,
  output lts_pkg::res_t   res
);

  logic [lts_pkg::SEQ_W-1:0]       next_seq_r, next_seq_nxt;
  logic                            tol_pend_r, tol_pend_nxt;
  logic                            waiting_r, waiting_nxt;
  logic [lts_pkg::BUF_W-1:0]       held_handle_r, held_handle_nxt;
  logic [lts_pkg::LEN_W-1:0]       held_len_r, held_len_nxt;
  logic [lts_pkg::SEQ_W-1:0]       held_seq_r, held_seq_nxt;
  logic                            held_flag_r, held_flag_nxt;
  logic [lts_pkg::COUNT_WIDTH-1:0] fail_r, fail_nxt;
  logic [lts_pkg::COUNT_WIDTH-1:0] samp_r, samp_nxt;

  logic [lts_pkg::COUNT_WIDTH-1:0] fail_inc, samp_inc;
  logic [lts_pkg::PROD_W-1:0]      fail_prod, thr_prod;
  logic                            is_send, is_resp, failed, tolerate;

  assign is_send = (req.req_type == lts_pkg::REQ_SEND) && !waiting_r;
  assign is_resp = ((req.req_type == lts_pkg::REQ_ACK) ||
                    (req.req_type == lts_pkg::REQ_TIMEOUT)) && waiting_r;
  assign failed  = (req.req_type == lts_pkg::REQ_TIMEOUT) || (req.ack_number != next_seq_r);

  assign fail_inc = (fail_r == lts_pkg::COUNT_MAX) ? fail_r : fail_r + 1'b1;
  assign samp_inc = (samp_r == lts_pkg::COUNT_MAX) ? samp_r : samp_r + 1'b1;

  // Exact ratio test on the updated counters.
  assign fail_prod = lts_pkg::PROD_W'(fail_inc) * lts_pkg::PROD_W'(lts_pkg::PCT_SCALE);
  assign thr_prod  = lts_pkg::PROD_W'(cfg.loss_threshold_pct) * lts_pkg::PROD_W'(samp_inc);
  assign tolerate  = fail_prod < thr_prod;

  always_comb begin
    next_seq_nxt    = next_seq_r;
    tol_pend_nxt    = tol_pend_r;
    waiting_nxt     = waiting_r;
    held_handle_nxt = held_handle_r;
    held_len_nxt    = held_len_r;
    held_seq_nxt    = held_seq_r;
    held_flag_nxt   = held_flag_r;
    fail_nxt        = fail_r;
    samp_nxt        = samp_r;

    res             = '0;
    res.result_kind = lts_pkg::KIND_IGNORED;

    if (is_send) begin
      held_handle_nxt = req.buffer_id & lts_pkg::HANDLE_MASK;
      held_len_nxt    = req.msg_len;
      held_seq_nxt    = next_seq_r;
      held_flag_nxt   = tol_pend_r;
      tol_pend_nxt    = 1'b0;
      next_seq_nxt    = (next_seq_r == lts_pkg::SEQ_ONE) ? lts_pkg::SEQ_TWO : lts_pkg::SEQ_ONE;
      waiting_nxt     = 1'b1;

      res.result_kind    = lts_pkg::KIND_TRANSMIT;
      res.seq_out        = next_seq_r;
      res.prev_tolerated = tol_pend_r;
      res.port_from      = cfg.src_port;
      res.port_to        = cfg.dst_port;
      res.payload_handle = req.buffer_id & lts_pkg::HANDLE_MASK;
      res.payload_len    = req.msg_len;
    end else if (is_resp) begin
      samp_nxt           = samp_inc;
      res.seq_out        = held_seq_r;
      res.prev_tolerated = held_flag_r;
      res.payload_handle = held_handle_r;
      res.payload_len    = held_len_r;
      if (!failed) begin
        waiting_nxt     = 1'b0;
        res.result_kind = lts_pkg::KIND_DELIVERED;
      end else begin
        fail_nxt = fail_inc;
        if (tolerate) begin
          tol_pend_nxt    = 1'b1;
          waiting_nxt     = 1'b0;
          res.result_kind = lts_pkg::KIND_TOLERATED;
        end else begin
          tol_pend_nxt    = 1'b0;
          res.result_kind = lts_pkg::KIND_TRANSMIT;
          res.port_from   = cfg.src_port;
          res.port_to     = cfg.dst_port;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r    <= lts_pkg::SEQ_ONE;
      tol_pend_r    <= 1'b0;
      waiting_r     <= 1'b0;
      held_handle_r <= '0;
      held_len_r    <= '0;
      held_seq_r    <= lts_pkg::SEQ_ONE;
      held_flag_r   <= 1'b0;
      fail_r        <= '0;
      samp_r        <= '0;
    end else if (step) begin
      next_seq_r    <= next_seq_nxt;
      tol_pend_r    <= tol_pend_nxt;
      waiting_r     <= waiting_nxt;
      held_handle_r <= held_handle_nxt;
      held_len_r    <= held_len_nxt;
      held_seq_r    <= held_seq_nxt;
      held_flag_r   <= held_flag_nxt;
      fail_r        <= fail_nxt;
      samp_r        <= samp_nxt;
    end
  end

endmodule

// File: design/loss_tolerant_stop_and_wait_sender_top.sv
// A request taken into the input register is evaluated by the core, and its result is
// registered into the result register when the result register is empty or being emptied.
// Throughput: one request per cycle unless the sink stalls; the input and result registers
// each hold one request, and the protocol state is updated as a request moves between them.
// Reset (rst_n low, synchronous): protocol state returns to sequence one, idle, counters zero;
// the threshold returns to 60 percent and both ports to zero; both registers are emptied.
// The configuration port is always ready.
module loss_tolerant_stop_and_wait_sender_top (
  input  logic      clk,
  input  logic      rst_n,
  lts_in_if.sink    in_if,
  lts_out_if.source out_if,
  lts_cfg_if.sink   cfg_if
);

  // Input register: captures each accepted request.
  logic          in_vld_r, in_vld_nxt;
  lts_pkg::req_t in_req_r;

  // Result register: holds one finished result until the sink takes it.
  logic          out_vld_r, out_vld_nxt;
  lts_pkg::res_t out_res_r;

  lts_pkg::cfg_t cfg;
  lts_pkg::res_t core_res;
  logic          advance;
  logic          in_take;

  // A request moves from the input register into the result register whenever the
  // result register is empty or is being emptied in this same cycle.
  assign advance      = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !in_vld_r || advance;
  assign in_take      = in_if.valid && in_if.ready;

  lts_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // The core evaluates the request held in the input register against the current
  // protocol state, and commits its state update only when the request advances.
  lts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .req   (in_req_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r.req_type   <= in_if.req_type;
      in_req_r.ack_number <= in_if.ack_number;
      in_req_r.buffer_id  <= in_if.buffer_id;
      in_req_r.msg_len    <= in_if.msg_len;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.result_kind    = out_res_r.result_kind;
  assign out_if.seq_out        = out_res_r.seq_out;
  assign out_if.prev_tolerated = out_res_r.prev_tolerated;
  assign out_if.port_from      = out_res_r.port_from;
  assign out_if.port_to        = out_res_r.port_to;
  assign out_if.payload_handle = out_res_r.payload_handle;
  assign out_if.payload_len    = out_res_r.payload_len;

endmodule

// File: design/lts_checker.sv
// Port-level checker for the sender and its bind to the top level.
module lts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lts_pkg::KIND_W-1:0]  result_kind,
  input logic [lts_pkg::SEQ_W-1:0]   seq_out,
  input logic                        prev_tolerated,
  input logic [lts_pkg::PORT_W-1:0]  port_from,
  input logic [lts_pkg::PORT_W-1:0]  port_to,
  input logic [lts_pkg::BUF_W-1:0]   payload_handle,
  input logic [lts_pkg::LEN_W-1:0]   payload_len
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(seq_out) &&
      $stable(payload_handle) && $stable(payload_len))
    else $error("result changed while stalled");

  // An ignored event carries nothing but its kind.
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == lts_pkg::KIND_IGNORED |->
      seq_out == '0 && !prev_tolerated && port_from == '0 && port_to == '0 &&
      payload_handle == '0 && payload_len == '0)
    else $error("ignored result carries data");

  // Finished exchanges carry no header ports.
  a_finish_no_ports: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == lts_pkg::KIND_DELIVERED ||
                  result_kind == lts_pkg::KIND_TOLERATED) |->
      port_from == '0 && port_to == '0)
    else $error("finished result carries ports");

  // Every non-ignored result names a valid alternating sequence number.
  a_seq_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind != lts_pkg::KIND_IGNORED |->
      seq_out == lts_pkg::SEQ_ONE || seq_out == lts_pkg::SEQ_TWO)
    else $error("bad sequence number");

endmodule

bind loss_tolerant_stop_and_wait_sender_top lts_checker u_lts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .result_kind    (out_if.result_kind),
  .seq_out        (out_if.seq_out),
  .prev_tolerated (out_if.prev_tolerated),
  .port_from      (out_if.port_from),
  .port_to        (out_if.port_to),
  .payload_handle (out_if.payload_handle),
  .payload_len    (out_if.payload_len)
);

// File: tb/loss_tolerant_stop_and_wait_sender_top_tb.sv
// Self-checking testbench for the stop-and-wait sender: directed, random and timeout-burst requests.
module loss_tolerant_stop_and_wait_sender_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lts_pkg::*;

  // The run is cut off here if results stop coming. The slowest correct run is roughly
  // 1850 requests plus the random gaps and the pauses between phases.
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASE_REQUESTS  = 250;
  localparam int unsigned PHASE_COUNT     = 7;
  // Length of the back-to-back timeout burst.
  localparam int unsigned TIMEOUT_BURST   = 40;
  localparam int unsigned MAX_GAP         = 11;

  // Codes the package leaves unnamed: the fourth request type and the two ack numbers
  // that can never match a sequence number.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [SEQ_W-1:0] SEQ_NONE   = 2'd0;
  localparam logic [SEQ_W-1:0] SEQ_BAD    = 2'd3;

  // Tracks the sender's protocol state, works out the result each accepted request must
  // produce and holds those results until the block delivers them.
  class sender_tracker;
    logic [PCT_W-1:0]       threshold_pct;
    logic [PORT_W-1:0]      src_port;
    logic [PORT_W-1:0]      dst_port;
    logic [SEQ_W-1:0]       next_seq;
    logic                   tolerate_pending;
    logic                   waiting_ack;
    logic [BUF_W-1:0]       held_handle;
    logic [LEN_W-1:0]       held_len;
    logic [SEQ_W-1:0]       held_seq;
    logic                   held_flag;
    logic [COUNT_WIDTH-1:0] fail_count;
    logic [COUNT_WIDTH-1:0] sample_count;
    res_t                   owed_results[$];
    int unsigned            mismatches;

    function new();
      threshold_pct    = THRESHOLD_RST;
      src_port         = '0;
      dst_port         = '0;
      next_seq         = SEQ_ONE;
      tolerate_pending = 1'b0;
      waiting_ack      = 1'b0;
      held_handle      = '0;
      held_len         = '0;
      held_seq         = SEQ_ONE;
      held_flag        = 1'b0;
      fail_count       = '0;
      sample_count     = '0;
      mismatches       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: threshold_pct = data[PCT_W-1:0];
        CFG_SRC_PORT:  src_port = data;
        CFG_DST_PORT:  dst_port = data;
        default: ;
      endcase
    endfunction

    function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // Header of the held packet; only a transmit carries the ports.
    function res_t held_packet(logic [KIND_W-1:0] kind);
      res_t r;
      r = '0;
      r.result_kind    = kind;
      r.seq_out        = held_seq;
      r.prev_tolerated = held_flag;
      r.payload_handle = held_handle;
      r.payload_len    = held_len;
      if (kind == KIND_TRANSMIT) begin
        r.port_from = src_port;
        r.port_to   = dst_port;
      end
      return r;
    endfunction

    function void note_request(req_t r);
      res_t                 want;
      logic                 failed;
      logic [31:0]          lost_scaled;
      logic [31:0]          allowed;
      want = '0;
      want.result_kind = KIND_IGNORED;
      if (r.req_type == REQ_SEND && !waiting_ack) begin
        held_handle      = r.buffer_id & HANDLE_MASK;
        held_len         = r.msg_len;
        held_seq         = next_seq;
        held_flag        = tolerate_pending;
        tolerate_pending = 1'b0;
        next_seq         = (next_seq == SEQ_ONE) ? SEQ_TWO : SEQ_ONE;
        waiting_ack      = 1'b1;
        want = held_packet(KIND_TRANSMIT);
      end else if ((r.req_type == REQ_ACK || r.req_type == REQ_TIMEOUT) && waiting_ack) begin
        failed = (r.req_type == REQ_TIMEOUT) || (r.ack_number != next_seq);
        sample_count = bump(sample_count);
        if (!failed) begin
          waiting_ack = 1'b0;
          want = held_packet(KIND_DELIVERED);
        end else begin
          fail_count  = bump(fail_count);
          lost_scaled = 32'(fail_count) * 32'(PCT_SCALE);
          allowed     = 32'(threshold_pct) * 32'(sample_count);
          if (lost_scaled < allowed) begin
            tolerate_pending = 1'b1;
            waiting_ack      = 1'b0;
            want = held_packet(KIND_TOLERATED);
          end else begin
            tolerate_pending = 1'b0;
            want = held_packet(KIND_TRANSMIT);
          end
        end
      end
      owed_results.push_back(want);
    endfunction

    // Every mismatch prints one line and is counted.
    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result of kind %0d arrived with nothing owed", got.result_kind));
        return;
      end
      want = owed_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0d, wanted %0d", got.result_kind, want.result_kind));
      if (got.seq_out !== want.seq_out)
        report($sformatf("seq_out %0d, wanted %0d", got.seq_out, want.seq_out));
      if (got.prev_tolerated !== want.prev_tolerated)
        report($sformatf("prev_tolerated %0b, wanted %0b", got.prev_tolerated,
                         want.prev_tolerated));
      if (got.port_from !== want.port_from)
        report($sformatf("port_from %h, wanted %h", got.port_from, want.port_from));
      if (got.port_to !== want.port_to)
        report($sformatf("port_to %h, wanted %h", got.port_to, want.port_to));
      if (got.payload_handle !== want.payload_handle)
        report($sformatf("payload_handle %h, wanted %h", got.payload_handle,
                         want.payload_handle));
      if (got.payload_len !== want.payload_len)
        report($sformatf("payload_len %h, wanted %h", got.payload_len, want.payload_len));
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  bit            no_idle;
  sender_tracker tracker;

  lts_in_if  in_ch();
  lts_out_if out_ch();
  lts_cfg_if cfg_ch();

  loss_tolerant_stop_and_wait_sender_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The cycle counter ends a run that hangs, for example when a result never shows up.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic req_t make_req(logic [REQ_W-1:0] kind, logic [SEQ_W-1:0] ackn,
                                    logic [BUF_W-1:0] handle, logic [LEN_W-1:0] len);
    req_t r;
    r.req_type   = kind;
    r.ack_number = ackn;
    r.buffer_id  = handle;
    r.msg_len    = len;
    return r;
  endfunction

  // Presents one request after a random gap and returns at the edge that accepts it.
  // The valid line is left high, so a request that follows with no gap keeps it high
  // without a second assignment in the same time step.
  task automatic push_request(req_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= r.req_type;
    in_ch.ack_number <= r.ack_number;
    in_ch.buffer_id  <= r.buffer_id;
    in_ch.msg_len    <= r.msg_len;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_request(r);
  endtask

  // Holds back new requests until every owed result has come out, then lets the
  // two-stage pipeline run dry.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(idx, data);
  endtask

  // Writes all three registers while the block is idle. The unused upper bits of the
  // threshold write carry random values, since only the low seven bits count.
  task automatic configure(logic [PCT_W-1:0] pct, logic [PORT_W-1:0] src,
                           logic [PORT_W-1:0] dst);
    logic [CFG_DAT_W-1:0] pct_word;
    settle();
    pct_word = CFG_DAT_W'($urandom);
    pct_word[PCT_W-1:0] = pct;
    write_reg(CFG_THRESHOLD, pct_word);
    write_reg(CFG_SRC_PORT, src);
    write_reg(CFG_DST_PORT, dst);
    cfg_ch.valid <= 1'b0;
  endtask

  // Most random requests follow the protocol: a send when the sender is idle, and an
  // ack or timeout while it waits, so that the loss counters keep moving. The rest are
  // noise of any type, which the block must ignore when it does not fit the state.
  function automatic req_t draw_request();
    req_t        r;
    int unsigned pick;
    r = make_req(REQ_W'($urandom), SEQ_W'($urandom), BUF_W'($urandom), LEN_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.req_type = REQ_W'($urandom);
    end else if (!tracker.waiting_ack) begin
      r.req_type = REQ_SEND;
    end else if (pick < 60) begin
      r.req_type   = REQ_ACK;
      r.ack_number = tracker.next_seq;
    end else if (pick < 80) begin
      r.req_type = REQ_ACK;
      while (r.ack_number == tracker.next_seq) r.ack_number = SEQ_W'($urandom);
    end else begin
      r.req_type = REQ_TIMEOUT;
    end
    return r;
  endfunction

  // Directed requests at reset settings (threshold 60 percent, ports zero). The comments
  // give the failure and sample counts after each ack or timeout.
  task automatic run_directed();
    push_request(make_req(REQ_ACK, SEQ_ONE, 8'h11, 16'h0001));       // ack while idle
    push_request(make_req(REQ_TIMEOUT, SEQ_TWO, 8'h22, 16'h0002));   // timeout while idle
    push_request(make_req(REQ_UNUSED, SEQ_BAD, 8'hFF, 16'hFFFF));    // unused type
    push_request(make_req(REQ_SEND, SEQ_NONE, 8'hFF, 16'hFFFF));     // first packet, seq one
    push_request(make_req(REQ_SEND, SEQ_ONE, 8'h33, 16'h0003));      // send while waiting
    push_request(make_req(REQ_UNUSED, SEQ_TWO, 8'h44, 16'h0004));    // unused type, waiting
    push_request(make_req(REQ_ACK, SEQ_TWO, 8'h00, 16'h0000));       // delivered, 0 of 1
    push_request(make_req(REQ_SEND, SEQ_BAD, 8'h00, 16'h0000));      // seq two
    push_request(make_req(REQ_ACK, SEQ_NONE, 8'h55, 16'h0005));      // 1 of 2: tolerated
    push_request(make_req(REQ_SEND, SEQ_NONE, 8'hA5, 16'h1234));     // flagged, seq one
    push_request(make_req(REQ_ACK, SEQ_BAD, 8'h66, 16'h0006));       // 2 of 3: resend
    push_request(make_req(REQ_TIMEOUT, SEQ_TWO, 8'h77, 16'h0007));   // 3 of 4: resend
    push_request(make_req(REQ_ACK, SEQ_ONE, 8'h88, 16'h0008));       // stale ack, 4 of 5
    push_request(make_req(REQ_ACK, SEQ_TWO, 8'h99, 16'h0009));       // delivered, 4 of 6
    push_request(make_req(REQ_SEND, SEQ_ONE, 8'h5A, 16'hEDCB));      // seq two, unflagged
    push_request(make_req(REQ_TIMEOUT, SEQ_ONE, 8'hAA, 16'h000A));   // 5 of 7: resend
    push_request(make_req(REQ_ACK, SEQ_ONE, 8'hBB, 16'h000B));       // delivered, 5 of 8
  endtask

  // A back-to-back burst of timeouts at a zero threshold, where every loss is resent,
  // then single timeouts at thresholds of exactly 100 and just above 100 percent.
  task automatic run_timeout_burst();
    configure(7'd0, PORT_W'($urandom), PORT_W'($urandom));
    no_idle = 1'b1;
    if (!tracker.waiting_ack)
      push_request(make_req(REQ_SEND, SEQ_NONE, BUF_W'($urandom), LEN_W'($urandom)));
    repeat (TIMEOUT_BURST)
      push_request(make_req(REQ_TIMEOUT, SEQ_W'($urandom), BUF_W'($urandom),
                            LEN_W'($urandom)));
    configure(PCT_SCALE, PORT_W'($urandom), PORT_W'($urandom));
    push_request(make_req(REQ_TIMEOUT, SEQ_ONE, 8'h01, 16'h0001));
    configure(PCT_SCALE + 7'd1, 16'hFFFF, 16'h0000);
    push_request(make_req(REQ_TIMEOUT, SEQ_TWO, 8'h02, 16'h0002));
    push_request(make_req(REQ_SEND, SEQ_NONE, 8'hC3, 16'h8001));
    push_request(make_req(REQ_ACK, tracker.next_seq, 8'h3C, 16'h7FFE));
    no_idle = 1'b0;
  endtask

  // Result side: stalls a random number of cycles before each result, or none at all
  // while the back-to-back phases run.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Every result accepted at a rising edge is checked against the oldest owed result.
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result_kind    = out_ch.result_kind;
      got.seq_out        = out_ch.seq_out;
      got.prev_tolerated = out_ch.prev_tolerated;
      got.port_from      = out_ch.port_from;
      got.port_to        = out_ch.port_to;
      got.payload_handle = out_ch.payload_handle;
      got.payload_len    = out_ch.payload_len;
      tracker.check_result(got);
    end
  end

  initial begin
    logic [PCT_W-1:0]  phase_pct[PHASE_COUNT];
    logic [PORT_W-1:0] src;
    logic [PORT_W-1:0] dst;
    tracker = new();
    no_idle = 1'b0;
    phase_pct = '{7'd0, 7'd100, 7'd127, 7'd1, THRESHOLD_RST, 7'd99, 7'd50};

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_SEND;
    in_ch.ack_number <= SEQ_NONE;
    in_ch.buffer_id  <= '0;
    in_ch.msg_len    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_THRESHOLD;
    cfg_ch.data      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Random phases, each under its own settings. Every phase begins with a pause that
    // waits for all owed results, which is also when the registers may be rewritten.
    // Two phases run with no idling on either side.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      src = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : PORT_W'($urandom);
      dst = (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : PORT_W'($urandom);
      configure((p == PHASE_COUNT - 1) ? PCT_W'($urandom_range(0, 127)) : phase_pct[p],
                src, dst);
      no_idle = (p == 3 || p == 5);
      repeat (PHASE_REQUESTS) push_request(draw_request());
    end
    no_idle = 1'b0;

    run_timeout_burst();
    settle();

    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
